>>> rtl/core/dct_pkg.sv
package dct_pkg;

   localparam int BLOCK_SIZE_DEF    = 8;
   localparam int COS_FRAC_BITS_DEF = 14;
   localparam int PIXEL_W           = 8;
   localparam int COEF_W            = 16;
   localparam int FREQ_W            = 3;
   localparam int ROW_W             = 32;
   localparam int ACC_W             = 56;

   // cos(k*pi/16) for k = 0..8 in Q2.30
   function automatic logic [31:0] cos_q30(input logic [3:0] k);
      logic [31:0] r;
      case (k)
         4'd0:    r = 32'd1073741824;
         4'd1:    r = 32'd1053110176;
         4'd2:    r = 32'd992008094;
         4'd3:    r = 32'd892783698;
         4'd4:    r = 32'd759250125;
         4'd5:    r = 32'd596538995;
         4'd6:    r = 32'd410903207;
         4'd7:    r = 32'd209476638;
         default: r = 32'd0;
      endcase
      return r;
   endfunction

   // signed basis weight W(k,n) in Q1.fb, 20 bits wide
   function automatic logic signed [19:0] weight(input logic [2:0] k, input logic [2:0] n,
                                                 input int fb);
      logic [5:0]  m;
      logic        neg;
      logic [31:0] base;
      logic [31:0] r;
      m   = 6'((({3'd0, n} * 6'd2 + 6'd1) * {3'd0, k}) % 32);
      neg = 1'b0;
      if (m > 6'd16) m = 6'd32 - m;
      if (m > 6'd8) begin
         m   = 6'd16 - m;
         neg = 1'b1;
      end
      base = (k == 3'd0) ? cos_q30(4'd4) : cos_q30(m[3:0]);
      r    = (base + (32'd1 << (29 - fb))) >> (30 - fb);
      return neg ? -$signed(20'(r)) : $signed(20'(r));
   endfunction

   typedef struct packed {
      logic       load;
      logic       row_mac;
      logic       row_store;
      logic       col_mac;
      logic       clear;
      logic [5:0] lidx;
      logic [2:0] a;
      logic [2:0] b;
      logic [2:0] k;
   } dct_cmd_type;

endpackage

>>> rtl/core/dct_stream_if.sv
interface dct_stream_if #(parameter int WIDTH = 8);
   logic             valid;
   logic             ready;
   logic [WIDTH-1:0] data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/core/dct_datapath.sv
module dct_datapath
   import dct_pkg::*;
#(
   parameter int COS_FRAC_BITS = COS_FRAC_BITS_DEF
) (
   input  logic                     clock,
   input  logic [PIXEL_W-1:0]       pixel,
   input  dct_cmd_type              cmd,
   output logic signed [COEF_W-1:0] coefficient
);
   localparam int SH = 2 * COS_FRAC_BITS - 2;

   logic [PIXEL_W-1:0]    pix_mem [64];
   logic signed [ROW_W-1:0] row_mem [64];
   logic [PIXEL_W-1:0]    pix_rd_ff;
   logic signed [ROW_W-1:0] row_rd_ff;
   logic signed [ACC_W-1:0] acc_ff, acc_in;
   logic signed [ACC_W-1:0] prod;
   logic signed [19:0]      w_ff;
   logic                    rmac_ff, cmac_ff;
   logic signed [ACC_W-1:0] rnd;
   logic signed [ACC_W-1:0] q;

   // store pixels and row results, read operands with a registered port
   always_ff @(posedge clock) begin
      if (cmd.load) pix_mem[cmd.lidx] <= pixel;
      pix_rd_ff <= pix_mem[{cmd.a, cmd.b}];
      row_rd_ff <= row_mem[{cmd.b, cmd.a}];
      w_ff      <= weight(cmd.k, cmd.b, COS_FRAC_BITS);
      rmac_ff   <= cmd.row_mac;
      cmac_ff   <= cmd.col_mac;
      if (cmd.row_store) row_mem[{cmd.lidx}] <= ROW_W'(acc_ff);
   end

   always_comb begin
      prod = '0;
      if (rmac_ff) prod = ACC_W'($signed({1'b0, pix_rd_ff})) * ACC_W'(w_ff);
      else if (cmac_ff) prod = ACC_W'(row_rd_ff) * ACC_W'(w_ff);
      acc_in = acc_ff;
      if (cmd.clear) acc_in = '0;
      else if (rmac_ff || cmac_ff) acc_in = acc_ff + prod;
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   // round half up and saturate
   always_comb begin
      rnd = acc_ff + (ACC_W'(1) <<< (SH - 1));
      q   = rnd >>> SH;
      if (q > ACC_W'(32767)) coefficient = 16'sh7fff;
      else if (q < ACC_W'(-32768)) coefficient = 16'sh8000;
      else coefficient = COEF_W'(q);
   end
endmodule

>>> rtl/core/dct_control.sv
module dct_control
   import dct_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   output logic              out_valid,
   input  logic              out_ready,
   output logic [FREQ_W-1:0] row_freq,
   output logic [FREQ_W-1:0] col_freq,
   output logic              last,
   output dct_cmd_type       cmd
);
   localparam logic [2:0] S_LOAD = 3'd0, S_ROW = 3'd1, S_RWB = 3'd2, S_COL = 3'd3,
                          S_CWB = 3'd4, S_OUT = 3'd5;

   logic [2:0] state_ff, state_in;
   logic [5:0] cnt_ff, cnt_in;   // load index or (row,col) target
   logic [3:0] step_ff, step_in; // tap 0..7 plus drain

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      step_in  = step_ff;
      cmd      = '0;
      cmd.lidx = cnt_ff;
      cmd.k    = (state_ff == S_ROW) ? cnt_ff[2:0] : cnt_ff[5:3];
      cmd.a    = (state_ff == S_ROW) ? cnt_ff[5:3] : cnt_ff[2:0];
      cmd.b    = step_ff[2:0];
      in_ready  = (state_ff == S_LOAD);
      out_valid = (state_ff == S_OUT);
      unique case (state_ff)
         S_LOAD: if (in_valid) begin
            cmd.load = 1'b1;
            cnt_in   = cnt_ff + 6'd1;
            if (cnt_ff == 6'd63) begin
               state_in = S_ROW;
               step_in  = '0;
               cmd.clear = 1'b1;
            end
         end
         S_ROW, S_COL: begin
            // issue one tap per cycle; the drain step (step 8) only drains the last product
            if (step_ff[3] == 1'b0) begin
               if (state_ff == S_ROW) cmd.row_mac = 1'b1;
               else cmd.col_mac = 1'b1;
            end
            step_in = step_ff + 4'd1;
            if (step_ff == 4'd8) state_in = (state_ff == S_ROW) ? S_RWB : S_CWB;
         end
         S_RWB: begin
            cmd.row_store = 1'b1;
            cmd.clear     = 1'b1;
            step_in       = '0;
            cnt_in        = cnt_ff + 6'd1;
            state_in      = (cnt_ff == 6'd63) ? S_COL : S_ROW;
         end
         S_CWB: state_in = S_OUT;
         S_OUT: if (out_ready) begin
            cmd.clear = 1'b1;
            step_in   = '0;
            cnt_in    = cnt_ff + 6'd1;
            state_in  = (cnt_ff == 6'd63) ? S_LOAD : S_COL;
         end
         default: state_in = S_LOAD;
      endcase
   end

   // the operand address is fed in the cycle before the multiply
   // so rmac/cmac in the datapath are asserted in the cycle after the issue
   assign row_freq = cnt_ff[5:3];
   assign col_freq = cnt_ff[2:0];
   assign last     = (cnt_ff == 6'd63);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_LOAD;
         cnt_ff   <= '0;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         step_ff  <= step_in;
      end
   end

   a_ready_load: assert property (@(posedge clock) disable iff (reset)
      in_ready |-> !out_valid) else $error("ready while emitting");
   a_wrap: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_LOAD && in_valid && cnt_ff == 6'd63) |=> state_ff == S_ROW)
      else $error("block not started");
   a_last: assert property (@(posedge clock) disable iff (reset)
      (out_valid && out_ready && last) |=> in_ready) else $error("no return to load");
endmodule

>>> rtl/core/dct_8x8_forward.sv
// Operation: after the 64th pixel is accepted, a row pass computes all 64 row
// targets, then a column pass computes and emits each coefficient in turn.
// One shared multiplier does all products: each row target takes its taps, a drain
// step and a write-back; each coefficient takes its taps, a drain step, a write-back
// and an emit that waits for rsp.ready; pixels are accepted only while loading.
// Reset: synchronous, active high; returns to loading with a zero pixel count.
module dct_8x8_forward
   import dct_pkg::*;
#(
   parameter int COS_FRAC_BITS = COS_FRAC_BITS_DEF
) (
   input  logic clock,
   input  logic reset,
   dct_stream_if.sink   req,
   dct_stream_if.source rsp
);
   dct_cmd_type               cmd;
   logic signed [COEF_W-1:0]  coef;
   logic [FREQ_W-1:0]         rf, cf;
   logic                      lst;

   dct_control u_ctl (
      .clock, .reset,
      .in_valid(req.valid), .in_ready(req.ready),
      .out_valid(rsp.valid), .out_ready(rsp.ready),
      .row_freq(rf), .col_freq(cf), .last(lst), .cmd(cmd)
   );

   dct_datapath #(.COS_FRAC_BITS(COS_FRAC_BITS)) u_dp (
      .clock, .pixel(req.data[PIXEL_W-1:0]), .cmd(cmd), .coefficient(coef)
   );

   assign rsp.data = {coef, rf, cf, lst};
endmodule

>>> bench/dct_checker.sv
module dct_checker
   import dct_pkg::*;
#(
   parameter int COS_FRAC_BITS = COS_FRAC_BITS_DEF
) (
   input  logic      clock,
   input  logic      reset,
   dct_stream_if     req,
   dct_stream_if     rsp,
   output int        errors,
   output int        pending
);

   typedef struct packed {
      logic signed [COEF_W-1:0] coefficient;
      logic [FREQ_W-1:0]        row_freq;
      logic [FREQ_W-1:0]        col_freq;
      logic                     last;
   } coef_type;

   // cos(k*pi/16) in Q2.30, k = 0..8
   localparam logic [31:0] COS_TABLE [0:8] = '{
      32'd1073741824, 32'd1053110176, 32'd992008094, 32'd892783698, 32'd759250125,
      32'd596538995, 32'd410903207, 32'd209476638, 32'd0
   };

   logic [7:0] block_pixels [0:63];
   logic [5:0] fill_count;
   coef_type   coef_queue [$];

   // basis weight for frequency f at sample position n, Q1.COS_FRAC_BITS
   function automatic longint basis(input int f, input int n);
      int          angle;
      bit          flip;
      logic [31:0] q30;
      longint      w;
      angle = ((2 * n + 1) * f) % 32;
      flip  = 1'b0;
      if (angle > 16) angle = 32 - angle;
      if (angle > 8) begin
         angle = 16 - angle;
         flip  = 1'b1;
      end
      q30 = (f == 0) ? COS_TABLE[4] : COS_TABLE[angle];
      w   = longint'((q30 + (32'd1 << (29 - COS_FRAC_BITS))) >> (30 - COS_FRAC_BITS));
      return flip ? -w : w;
   endfunction

   // separable 2-D transform of the stored block, queue all 64 coefficients
   task automatic predict_block();
      longint   rows [0:63];
      longint   acc;
      longint   q;
      coef_type c;
      for (int x = 0; x < 8; x++) begin
         for (int v = 0; v < 8; v++) begin
            acc = 0;
            for (int y = 0; y < 8; y++) acc += longint'(block_pixels[x*8+y]) * basis(v, y);
            rows[x*8+v] = acc;
         end
      end
      for (int u = 0; u < 8; u++) begin
         for (int v = 0; v < 8; v++) begin
            acc = 0;
            for (int x = 0; x < 8; x++) acc += basis(u, x) * rows[x*8+v];
            q = (acc + (64'sd1 <<< (2*COS_FRAC_BITS-3))) >>> (2*COS_FRAC_BITS-2);
            if (q > 32767) q = 32767;
            if (q < -32768) q = -32768;
            c.coefficient = q[15:0];
            c.row_freq    = u[2:0];
            c.col_freq    = v[2:0];
            c.last        = (u == 7 && v == 7);
            coef_queue.push_back(c);
         end
      end
   endtask

   // collect requests, then compare each response with the oldest prediction
   always @(posedge clock) begin
      coef_type got;
      coef_type want;
      int       bad;
      bad = 0;
      if (reset) begin
         fill_count <= '0;
         errors     <= 0;
         pending    <= 0;
         coef_queue.delete();
      end else begin
         if (req.valid && req.ready) begin
            block_pixels[fill_count] = req.data;
            fill_count <= fill_count + 6'd1;
            if (fill_count == 6'd63) predict_block();
         end
         if (rsp.valid && rsp.ready) begin
            got = rsp.data;
            if (coef_queue.size() == 0) begin
               $error("unexpected coefficient %h", got);
               bad = bad + 1;
            end else begin
               want = coef_queue.pop_front();
               if (got.coefficient !== want.coefficient) begin
                  $error("coefficient expected %0d actual %0d",
                         want.coefficient, got.coefficient);
                  bad = bad + 1;
               end
               if (got.row_freq !== want.row_freq) begin
                  $error("row_freq expected %0d actual %0d", want.row_freq, got.row_freq);
                  bad = bad + 1;
               end
               if (got.col_freq !== want.col_freq) begin
                  $error("col_freq expected %0d actual %0d", want.col_freq, got.col_freq);
                  bad = bad + 1;
               end
               if (got.last !== want.last) begin
                  $error("last expected %0d actual %0d", want.last, got.last);
                  bad = bad + 1;
               end
            end
         end
         errors  <= errors + bad;
         pending <= coef_queue.size();
      end
   end

endmodule

>>> bench/dct_8x8_forward_tb.sv
module dct_8x8_forward_tb;
   import dct_pkg::*;

   localparam int RSP_W = COEF_W + 2 * FREQ_W + 1;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   errors;
   int   pending;
   bit   quiet = 1'b0;
   bit   hold_off = 1'b0;

   dct_stream_if #(.WIDTH(PIXEL_W)) req ();
   dct_stream_if #(.WIDTH(RSP_W))   rsp ();

   dct_8x8_forward uut (.clock(clock), .reset(reset), .req(req), .rsp(rsp));

   dct_checker checker_i (.clock(clock), .reset(reset), .req(req), .rsp(rsp),
                          .errors(errors), .pending(pending));

   always #1 clock = ~clock;

   // offer one request, optionally after a random idle burst
   task automatic send_pixel(input logic [7:0] pix);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req.valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req.valid <= 1'b1;
      req.data  <= pix;
      do @(posedge clock); while (!req.ready);
   endtask

   // random pixel: mostly uniform, sometimes an extreme
   function automatic logic [7:0] rand_pixel();
      case ($urandom_range(0, 5))
         0:       return 8'd0;
         1:       return 8'd255;
         default: return 8'($urandom());
      endcase
   endfunction

   // response side: random stall bursts, one long hold-off, none at the end
   initial begin
      rsp.ready = 1'b0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (hold_off) begin
            rsp.ready <= 1'b0;
            repeat (3000) @(posedge clock);
            hold_off = 1'b0;
         end else if (!quiet && $urandom_range(0, 4) == 0) begin
            rsp.ready <= 1'b0;
            repeat ($urandom_range(1, 8) - 1) @(posedge clock);
         end else begin
            rsp.ready <= 1'b1;
         end
      end
   end

   initial begin
      req.valid = 1'b0;
      req.data  = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // full-scale block
      for (int i = 0; i < 64; i++) send_pixel(8'd255);

      // hold responses off while requests are offered: checkerboard, then random
      hold_off = 1'b1;
      for (int i = 0; i < 64; i++) send_pixel(((i / 8 + i) % 2) ? 8'd255 : 8'd0);
      for (int i = 0; i < 64; i++) send_pixel(rand_pixel());

      // drain fully before the next block
      req.valid <= 1'b0;
      do @(posedge clock); while (pending != 0);

      for (int i = 0; i < 32; i++) send_pixel(rand_pixel());
      quiet = 1'b1;
      for (int i = 0; i < 32; i++) send_pixel(8'($urandom()));
      for (int i = 0; i < 24; i++) send_pixel(8'($urandom()));
      req.valid <= 1'b0;

      do @(posedge clock); while (pending != 0);
      repeat (50) @(posedge clock);
      if (errors == 0) $display("DONE: 0 errors");
      else $display("DONE: errors detected");
      $finish;
   end

   initial begin
      #2000000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule

>>> filelist.f
rtl/core/dct_pkg.sv
rtl/core/dct_stream_if.sv
rtl/core/dct_datapath.sv
rtl/core/dct_control.sv
rtl/core/dct_8x8_forward.sv
bench/dct_checker.sv
bench/dct_8x8_forward_tb.sv
